>>> rtl/core/dssl_pkg.sv
// Package for the dual servo slew limiter: field widths, limits, register
// indexes and the structs passed between the channel logic and the top level.
// No dependencies.
package dssl_pkg;

    localparam int TARGET_W  = 7;
    localparam int SPEED_W   = 7;
    localparam int POS_W     = 8;
    localparam int ELAPSED_W = 7;
    localparam int DRIVE_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    localparam int MAX_INTERVAL = 100;
    localparam int SPEED_LIMIT  = 100;
    localparam int TARGET_LIMIT = 90;
    localparam int SPEED_RESET  = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_B = 1'd1;

    typedef logic [TARGET_W-1:0]         t_target;
    typedef logic [SPEED_W-1:0]          t_speed;
    typedef logic signed [POS_W-1:0]     t_pos;
    typedef logic [ELAPSED_W-1:0]        t_elapsed;
    typedef logic [DRIVE_W-1:0]          t_drive;

    typedef struct packed {
        t_pos     pos;
        t_elapsed elapsed;
    } t_chan_state;

    typedef struct packed {
        t_pos   position;
        logic   write;
        t_drive drive;
    } t_chan_res;

endpackage

>>> rtl/core/dssl_in_if.sv
// Input channel of the dual servo slew limiter: one word carries both targets.
// Depends on dssl_pkg.
interface dssl_in_if;
    logic               valid;
    logic               ready;
    dssl_pkg::t_target  target_a;
    dssl_pkg::t_target  target_b;

    modport source (output valid, output target_a, output target_b, input ready);
    modport sink   (input valid, input target_a, input target_b, output ready);
endinterface

>>> rtl/core/dssl_out_if.sv
// Result channel of the dual servo slew limiter: positions, write flags and
// drive angles of both channels. Depends on dssl_pkg.
interface dssl_out_if;
    logic               valid;
    logic               ready;
    dssl_pkg::t_pos     position_a;
    logic               write_a;
    dssl_pkg::t_drive   drive_a;
    dssl_pkg::t_pos     position_b;
    logic               write_b;
    dssl_pkg::t_drive   drive_b;

    modport source (output valid, output position_a, output write_a, output drive_a,
                    output position_b, output write_b, output drive_b, input ready);
    modport sink   (input valid, input position_a, input write_a, input drive_a,
                    input position_b, input write_b, input drive_b, output ready);
endinterface

>>> rtl/core/dssl_cfg_if.sv
// Configuration write channel of the dual servo slew limiter: register index
// and write data. Depends on dssl_pkg.
interface dssl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dssl_pkg::CFG_IDX_W-1:0]    index;
    logic [dssl_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/dssl_cfg_regs.sv
// Speed registers of the dual servo slew limiter, written over the
// configuration channel. Depends on dssl_pkg and dssl_cfg_if.
module dssl_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dssl_cfg_if.sink          i_cfg,
    output dssl_pkg::t_speed  o_speed_a,
    output dssl_pkg::t_speed  o_speed_b
);
    import dssl_pkg::*;

    t_speed r_speed_a;
    t_speed r_speed_b;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_a <= SPEED_W'(SPEED_RESET);
            r_speed_b <= SPEED_W'(SPEED_RESET);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SPEED_A: r_speed_a <= i_cfg.data;
                CFG_SPEED_B: r_speed_b <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign o_speed_a = r_speed_a;
    assign o_speed_b = r_speed_b;

endmodule

>>> rtl/core/dssl_chan.sv
// Step logic of one servo channel: window counter, one-unit move toward the
// target and drive value. Purely combinational. Depends on dssl_pkg.
module dssl_chan (
    input  dssl_pkg::t_speed       i_speed,
    input  dssl_pkg::t_target      i_target,
    input  dssl_pkg::t_chan_state  i_state,
    output dssl_pkg::t_chan_state  o_state,
    output dssl_pkg::t_chan_res    o_res
);
    import dssl_pkg::*;

    t_speed   sp;
    t_elapsed interval;
    t_target  tgt_clip;
    t_pos     tgt;
    t_elapsed elapsed_inc;
    logic     window;
    t_pos     pos_nxt;
    logic     wrote;

    always_comb begin
        sp = (i_speed > SPEED_W'(SPEED_LIMIT)) ? SPEED_W'(SPEED_LIMIT) : i_speed;
        interval = (ELAPSED_W'(sp) >= ELAPSED_W'(MAX_INTERVAL)) ? '0
                 : ELAPSED_W'(MAX_INTERVAL) - ELAPSED_W'(sp);
        tgt_clip = (i_target > TARGET_W'(TARGET_LIMIT)) ? TARGET_W'(TARGET_LIMIT) : i_target;
        tgt = POS_W'({1'b0, tgt_clip});
        elapsed_inc = i_state.elapsed + ELAPSED_W'(1);
        window = elapsed_inc > interval;
        pos_nxt = i_state.pos;
        wrote = 1'b0;
        if (window) begin
            if (i_state.pos > tgt) begin
                pos_nxt = i_state.pos - POS_W'(1);
                wrote = 1'b1;
            end else if (i_state.pos < tgt) begin
                pos_nxt = i_state.pos + POS_W'(1);
                wrote = 1'b1;
            end
        end
        o_state.pos = pos_nxt;
        o_state.elapsed = window ? '0 : elapsed_inc;
        o_res.position = pos_nxt;
        o_res.write = wrote;
        o_res.drive = pos_nxt[POS_W-1] ? '0 : {pos_nxt[POS_W-2:0], 1'b0};
    end

endmodule

>>> rtl/core/dual_servo_slew_limiter_core.sv
// Top level of the dual servo slew limiter: input register, two channel step
// units, channel state and result register. Depends on dssl_pkg, the three
// channel interfaces, dssl_cfg_regs and dssl_chan.
//
// Each input word is one millisecond tick carrying the targets of channels A
// and B. Every accepted word yields exactly one result word with the position,
// write flag and drive angle of both channels after that tick.
// The configuration channel writes the speed registers (index 0 for channel A,
// index 1 for channel B) and is always ready; both reset to 20.
// A word passes through two registers: the accepting edge loads the input
// register, and a later edge on which the result register is free moves the
// word through the step logic into the result register. The core takes one
// word per cycle while the receiver does not stall, as the step of each
// channel between the two registers is combinational.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; input ready drops only when both are
// full. Reset clears both valid flags, sets both positions to minus one so
// that the first window always writes, and clears the tick counters.
module dual_servo_slew_limiter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dssl_in_if.sink     i_in,
    dssl_cfg_if.sink    i_cfg,
    dssl_out_if.source  o_out
);
    import dssl_pkg::*;

    t_speed      speed_a;
    t_speed      speed_b;

    logic        r_in_valid;
    t_target     r_tgt_a;
    t_target     r_tgt_b;

    t_chan_state r_st_a;
    t_chan_state r_st_b;
    t_chan_state n_st_a;
    t_chan_state n_st_b;

    logic        r_out_valid;
    t_chan_res   r_res_a;
    t_chan_res   r_res_b;
    t_chan_res   n_res_a;
    t_chan_res   n_res_b;

    logic        move;

    dssl_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_speed_a (speed_a),
        .o_speed_b (speed_b)
    );

    dssl_chan u_chan_a (
        .i_speed  (speed_a),
        .i_target (r_tgt_a),
        .i_state  (r_st_a),
        .o_state  (n_st_a),
        .o_res    (n_res_a)
    );

    dssl_chan u_chan_b (
        .i_speed  (speed_b),
        .i_target (r_tgt_b),
        .i_state  (r_st_b),
        .o_state  (n_st_b),
        .o_res    (n_res_b)
    );

    assign move = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_tgt_a <= i_in.target_a;
            r_tgt_b <= i_in.target_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_a.pos     <= -POS_W'(1);
            r_st_a.elapsed <= '0;
            r_st_b.pos     <= -POS_W'(1);
            r_st_b.elapsed <= '0;
        end else if (move) begin
            r_st_a <= n_st_a;
            r_st_b <= n_st_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_res_a <= n_res_a;
            r_res_b <= n_res_b;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.position_a = r_res_a.position;
    assign o_out.write_a    = r_res_a.write;
    assign o_out.drive_a    = r_res_a.drive;
    assign o_out.position_b = r_res_b.position;
    assign o_out.write_b    = r_res_b.write;
    assign o_out.drive_b    = r_res_b.drive;

endmodule
